// ===== rtl/mdpc_pkg.sv =====
// shared types and constants for the multi-input debounce pulse counter
package mdpc_pkg;

    localparam int MAX_INPUTS   = 8;
    localparam int NUM_INPUTS_DEF = 8;
    localparam int FILTER_W     = 16;
    localparam int PULSE_W      = 16;
    localparam logic [FILTER_W-1:0] FILTER_RESET = 16'd10;

    // output word layout, lowest bit first
    localparam int ACT_LSB      = 0;
    localparam int CHG_LSB      = ACT_LSB + MAX_INPUTS;
    localparam int ANY_BIT      = CHG_LSB + MAX_INPUTS;
    localparam int PULSE_LSB    = ANY_BIT + 1;
    localparam int OUT_USED     = PULSE_LSB + MAX_INPUTS * PULSE_W;
    localparam int OUT_W        = ((OUT_USED + 7) / 8) * 8;

    // what one lane reports for the word being accepted
    typedef struct packed {
        logic               active;
        logic               change;
        logic [PULSE_W-1:0] pulses;
    } lane_res_t;

endpackage

// ===== rtl/mdpc_lane.sv =====
// one debounce lane: filter counter, debounced state and pulse counter
module mdpc_lane (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         pin_level,
    input  logic [mdpc_pkg::FILTER_W-1:0] filter_time,
    output mdpc_pkg::lane_res_t          res
);

    logic [mdpc_pkg::FILTER_W-1:0] count_reg, count_next;
    logic                          state_reg, state_next;
    logic [mdpc_pkg::PULSE_W-1:0]  pulse_reg, pulse_next;
    logic                          change;

    always_comb begin
        count_next = count_reg;
        state_next = state_reg;
        if (!pin_level) begin
            if (count_reg < filter_time) begin
                count_next = count_reg + 1'b1;
            end else begin
                state_next = 1'b1;
            end
        end else begin
            count_next = '0;
            state_next = 1'b0;
        end
        change     = state_next != state_reg;
        pulse_next = pulse_reg + {{(mdpc_pkg::PULSE_W-1){1'b0}}, change & state_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            state_reg <= 1'b0;
            pulse_reg <= '0;
        end else if (step) begin
            count_reg <= count_next;
            state_reg <= state_next;
            pulse_reg <= pulse_next;
        end
    end

    assign res.active = state_next;
    assign res.change = change;
    assign res.pulses = pulse_next;

endmodule

// ===== rtl/mdpc_merge.sv =====
// merges the lane results into one output word and holds it in the output register
module mdpc_merge (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       load,
    input  mdpc_pkg::lane_res_t [mdpc_pkg::MAX_INPUTS-1:0] lanes,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [mdpc_pkg::OUT_W-1:0]                 m_tdata
);

    logic                          valid_reg, valid_next;
    logic [mdpc_pkg::OUT_W-1:0]    data_reg, data_next;
    logic [mdpc_pkg::MAX_INPUTS-1:0] act, chg;

    always_comb begin
        data_next = '0;
        for (int k = 0; k < mdpc_pkg::MAX_INPUTS; k++) begin
            act[k] = lanes[k].active;
            chg[k] = lanes[k].change;
            data_next[mdpc_pkg::PULSE_LSB + k*mdpc_pkg::PULSE_W +: mdpc_pkg::PULSE_W] =
                lanes[k].pulses;
        end
        data_next[mdpc_pkg::ACT_LSB +: mdpc_pkg::MAX_INPUTS] = act;
        data_next[mdpc_pkg::CHG_LSB +: mdpc_pkg::MAX_INPUTS] = chg;
        data_next[mdpc_pkg::ANY_BIT] = |chg;
        valid_next = load | (valid_reg & ~m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== rtl/multi_input_debounce_pulse_counter.sv =====
// top level of the multi-input debounce pulse counter
//
// Each input word is one scan tick of up to eight active-low pins. Every pin has
// its own lane: a filter counter climbs on low samples up to filter_time, a
// further low sample makes the input active, and any high sample clears counter
// and state at once. A transition to active bumps that input's 16-bit pulse
// counter, which wraps. One result word per input word, one word per clock:
// the lanes update in the accept cycle and the merged result lands in a single
// output register, so a new word is taken while the previous result is being
// taken by the sink; only a stalled output register holds the input off.
// filter_time resets to 10 and is written through the cfg channel, which is
// always ready; write it only while the block is idle.
module multi_input_debounce_pulse_counter #(
    parameter int NUM_INPUTS = mdpc_pkg::NUM_INPUTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pin_levels
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] active_mask, [15:8] change_mask, [16] any_change,
    // [32:17] pulses_in0 .. [144:129] pulses_in7, [151:145] zero
    output logic [mdpc_pkg::OUT_W-1:0]    m_tdata,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mdpc_pkg::FILTER_W-1:0] cfg_data    // [15:0] filter_time
);

    logic [mdpc_pkg::FILTER_W-1:0]                 filter_time_reg;
    logic                                          accept;
    mdpc_pkg::lane_res_t [mdpc_pkg::MAX_INPUTS-1:0] lanes;

    // output register frees up when empty or being drained this cycle
    assign s_tready  = ~m_tvalid | m_tready;
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_time_reg <= mdpc_pkg::FILTER_RESET;
        end else if (cfg_valid) begin
            filter_time_reg <= cfg_data;
        end
    end

    // one lane per populated input, unused inputs report zeros
    for (genvar k = 0; k < mdpc_pkg::MAX_INPUTS; k++) begin : g_lane
        if (k < NUM_INPUTS) begin : g_used
            mdpc_lane u_lane (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .step        (accept),
                .pin_level   (s_tdata[k]),
                .filter_time (filter_time_reg),
                .res         (lanes[k])
            );
        end else begin : g_unused
            assign lanes[k] = '0;
        end
    end

    mdpc_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .lanes    (lanes),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
